// ===== rtl/core/set_assoc_writeback_cache_tags_macros.svh =====
`ifndef SET_ASSOC_WRITEBACK_CACHE_TAGS_MACROS_SVH
`define SET_ASSOC_WRITEBACK_CACHE_TAGS_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SAWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SAWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sawc_pkg.sv =====
package sawc_pkg;

    localparam int NUM_SETS    = 8;
    localparam int NUM_WAYS    = 4;
    localparam int BLOCK_BYTES = 32;
    localparam int COUNT_BITS  = 32;

    localparam int ADDR_BITS  = 32;
    localparam int OFF_BITS   = $clog2(BLOCK_BYTES);
    localparam int SET_BITS   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SET_USED   = $clog2(NUM_SETS);
    localparam int TAG_BITS   = ADDR_BITS - OFF_BITS - SET_USED;
    localparam int WAY_BITS   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int LAT_BITS   = 9;
    localparam int CFG_LAT_BITS = 8;
    localparam int OUT_COUNT_BITS = 32;

    localparam int PADDR_BITS   = 5;
    localparam int PDATA_BITS   = 32;
    localparam int REG_IDX_BITS = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_CACHE_ENABLE      = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_READ_LATENCY      = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_WRITE_LATENCY     = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_FILL_LATENCY      = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_WRITEBACK_LATENCY = 3'd4;

    localparam logic                    RST_CACHE_ENABLE      = 1'b1;
    localparam logic [CFG_LAT_BITS-1:0] RST_READ_LATENCY      = 8'd30;
    localparam logic [CFG_LAT_BITS-1:0] RST_WRITE_LATENCY     = 8'd30;
    localparam logic [CFG_LAT_BITS-1:0] RST_FILL_LATENCY      = 8'd30;
    localparam logic [CFG_LAT_BITS-1:0] RST_WRITEBACK_LATENCY = 8'd10;

    typedef struct packed {
        logic                    enable;
        logic [CFG_LAT_BITS-1:0] rd_lat;
        logic [CFG_LAT_BITS-1:0] wr_lat;
        logic [CFG_LAT_BITS-1:0] fill_lat;
        logic [CFG_LAT_BITS-1:0] wb_lat;
    } t_cfg;

    typedef struct packed {
        logic                store;
        logic [SET_BITS-1:0] set_idx;
        logic [TAG_BITS-1:0] tag;
    } t_lookup_req;

    typedef struct packed {
        logic hit;
        logic writeback;
    } t_lookup_rsp;

    typedef struct packed {
        logic load;
        logic store;
        logic load_miss;
        logic store_miss;
        logic writeback;
    } t_stat_evt;

    typedef struct packed {
        logic [COUNT_BITS-1:0] loads;
        logic [COUNT_BITS-1:0] stores;
        logic [COUNT_BITS-1:0] ld_misses;
        logic [COUNT_BITS-1:0] st_misses;
        logic [COUNT_BITS-1:0] writebacks;
    } t_counts;

endpackage

// ===== rtl/core/sawc_cfg.sv =====
module sawc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sawc_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [sawc_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [sawc_pkg::PDATA_BITS-1:0]  prdata,
    output logic                             pready,
    output sawc_pkg::t_cfg                   o_cfg
);
    import sawc_pkg::*;

    t_cfg                    r_cfg;
    logic                    wr_en;
    logic [REG_IDX_BITS-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_BITS-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable   <= RST_CACHE_ENABLE;
            r_cfg.rd_lat   <= RST_READ_LATENCY;
            r_cfg.wr_lat   <= RST_WRITE_LATENCY;
            r_cfg.fill_lat <= RST_FILL_LATENCY;
            r_cfg.wb_lat   <= RST_WRITEBACK_LATENCY;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CACHE_ENABLE:      r_cfg.enable   <= pwdata[0];
                REG_READ_LATENCY:      r_cfg.rd_lat   <= pwdata[CFG_LAT_BITS-1:0];
                REG_WRITE_LATENCY:     r_cfg.wr_lat   <= pwdata[CFG_LAT_BITS-1:0];
                REG_FILL_LATENCY:      r_cfg.fill_lat <= pwdata[CFG_LAT_BITS-1:0];
                REG_WRITEBACK_LATENCY: r_cfg.wb_lat   <= pwdata[CFG_LAT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CACHE_ENABLE:      prdata = PDATA_BITS'(r_cfg.enable);
            REG_READ_LATENCY:      prdata = PDATA_BITS'(r_cfg.rd_lat);
            REG_WRITE_LATENCY:     prdata = PDATA_BITS'(r_cfg.wr_lat);
            REG_FILL_LATENCY:      prdata = PDATA_BITS'(r_cfg.fill_lat);
            REG_WRITEBACK_LATENCY: prdata = PDATA_BITS'(r_cfg.wb_lat);
            default:               prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/sawc_tags.sv =====
`include "set_assoc_writeback_cache_tags_macros.svh"

module sawc_tags (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  sawc_pkg::t_lookup_req i_req,
    output sawc_pkg::t_lookup_rsp o_rsp
);
    import sawc_pkg::*;

    logic [TAG_BITS-1:0] r_tag   [NUM_WAYS][NUM_SETS];
    logic [NUM_SETS-1:0] r_valid [NUM_WAYS];
    logic [NUM_SETS-1:0] r_dirty [NUM_WAYS];
    logic [WAY_BITS-1:0] r_vptr  [NUM_SETS];

    logic [NUM_WAYS-1:0] match;
    logic [WAY_BITS-1:0] hit_way;
    logic [WAY_BITS-1:0] vic;
    logic [WAY_BITS-1:0] n_vptr;
    logic                hit;
    logic                vic_dirty;

    always_comb begin
        hit_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            match[w] = r_valid[w][i_req.set_idx] && (r_tag[w][i_req.set_idx] == i_req.tag);
            if (match[w]) begin
                hit_way = WAY_BITS'(w);
            end
        end
    end

    assign hit       = |match;
    assign vic       = r_vptr[i_req.set_idx];
    assign vic_dirty = r_dirty[vic][i_req.set_idx];
    assign n_vptr    = (vic == WAY_BITS'(NUM_WAYS - 1)) ? '0 : vic + 1'b1;

    assign o_rsp.hit       = hit;
    assign o_rsp.writeback = !hit && vic_dirty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                r_valid[w] <= '0;
                r_dirty[w] <= '0;
            end
            for (int s = 0; s < NUM_SETS; s++) begin
                r_vptr[s] <= '0;
            end
        end else if (i_fire) begin
            if (hit) begin
                if (i_req.store) begin
                    r_dirty[hit_way][i_req.set_idx] <= 1'b1;
                end
            end else begin
                r_valid[vic][i_req.set_idx] <= 1'b1;
                r_dirty[vic][i_req.set_idx] <= i_req.store;
                r_vptr[i_req.set_idx]       <= n_vptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && !hit) begin
            r_tag[vic][i_req.set_idx] <= i_req.tag;
        end
    end

    `SAWC_ASSERT_NOW(a_single_match, i_clk, i_rst_n, i_fire, $onehot0(match), "tag matched in more than one way")
    `SAWC_ASSERT_NEXT(a_store_hit_dirty, i_clk, i_rst_n, i_fire && i_req.store && hit, r_dirty[$past(hit_way)][$past(i_req.set_idx)], "store hit left line clean")
    `SAWC_ASSERT_NEXT(a_fill_valid, i_clk, i_rst_n, i_fire && !hit, r_valid[$past(vic)][$past(i_req.set_idx)], "filled line not valid")

endmodule

// ===== rtl/core/sawc_stats.sv =====
module sawc_stats (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  sawc_pkg::t_stat_evt i_evt,
    output sawc_pkg::t_counts   o_counts
);
    import sawc_pkg::*;

    t_counts r_counts;
    t_counts n_counts;

    always_comb begin
        n_counts.loads      = r_counts.loads      + COUNT_BITS'(i_evt.load);
        n_counts.stores     = r_counts.stores     + COUNT_BITS'(i_evt.store);
        n_counts.ld_misses  = r_counts.ld_misses  + COUNT_BITS'(i_evt.load_miss);
        n_counts.st_misses  = r_counts.st_misses  + COUNT_BITS'(i_evt.store_miss);
        n_counts.writebacks = r_counts.writebacks + COUNT_BITS'(i_evt.writeback);
    end

    assign o_counts = n_counts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts <= '0;
        end else if (i_fire) begin
            r_counts <= n_counts;
        end
    end

endmodule

// ===== rtl/core/set_assoc_writeback_cache_tags.sv =====
// Tag, valid and dirty tracking for a write-back set-associative cache (8 sets, 4 ways,
// 32-byte lines, round-robin victim per set). One access enters per cycle unless the input
// is stalled. The access is captured in an input register, the set lookup, victim choice,
// state update and counter increment are done between the input and output registers,
// and the result is held in the output register. The input stalls only while both
// registers hold an access and the output is stalled.
// Back-to-back accesses to the same set see each other's updates. With cache_enable at 0
// the block reports the read or write latency and leaves all state and counters alone.
// Configuration is through the APB port, register i at byte address 4*i.
`include "set_assoc_writeback_cache_tags_macros.svh"

module set_assoc_writeback_cache_tags (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sawc_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [sawc_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [sawc_pkg::PDATA_BITS-1:0]  prdata,
    output logic                             pready,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_mode,
    input  logic [31:0]                      i_addr,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [8:0]                       o_latency,
    output logic                             o_hit,
    output logic                             o_did_writeback,
    output logic [31:0]                      o_load_total,
    output logic [31:0]                      o_store_total,
    output logic [31:0]                      o_load_miss_total,
    output logic [31:0]                      o_store_miss_total,
    output logic [31:0]                      o_writeback_total
);
    import sawc_pkg::*;

    t_cfg        cfg;
    t_lookup_req req;
    t_lookup_rsp rsp;
    t_stat_evt   evt;
    t_counts     counts;

    logic                 r_s1_valid;
    logic                 r_s1_mode;
    logic [ADDR_BITS-1:0] r_s1_addr;

    logic                 r_out_valid;
    logic [LAT_BITS-1:0]  r_lat;
    logic                 r_hit;
    logic                 r_wb;
    t_counts              r_counts;

    logic                 advance;
    logic                 accept;
    logic                 lookup_fire;
    logic [LAT_BITS-1:0]  n_lat;

    sawc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign advance     = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_s1_valid && r_out_valid && i_stall;
    assign accept      = i_valid && !o_stall;
    assign lookup_fire = advance && cfg.enable;

    assign req.store   = r_s1_mode;
    assign req.set_idx = SET_BITS'(r_s1_addr >> OFF_BITS);
    assign req.tag     = r_s1_addr[ADDR_BITS-1 -: TAG_BITS];

    sawc_tags u_tags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (lookup_fire),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    assign evt.load       = cfg.enable && !r_s1_mode;
    assign evt.store      = cfg.enable && r_s1_mode;
    assign evt.load_miss  = cfg.enable && !r_s1_mode && !rsp.hit;
    assign evt.store_miss = cfg.enable && r_s1_mode && !rsp.hit;
    assign evt.writeback  = cfg.enable && rsp.writeback;

    sawc_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_evt    (evt),
        .o_counts (counts)
    );

    always_comb begin
        if (!cfg.enable) begin
            n_lat = LAT_BITS'(r_s1_mode ? cfg.wr_lat : cfg.rd_lat);
        end else if (rsp.hit) begin
            n_lat = '0;
        end else begin
            n_lat = LAT_BITS'(cfg.fill_lat)
                  + (rsp.writeback ? LAT_BITS'(cfg.wb_lat) : LAT_BITS'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode <= i_mode;
            r_s1_addr <= i_addr;
        end
        if (advance) begin
            r_lat    <= n_lat;
            r_hit    <= cfg.enable && rsp.hit;
            r_wb     <= cfg.enable && rsp.writeback;
            r_counts <= counts;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_latency          = r_lat;
    assign o_hit              = r_hit;
    assign o_did_writeback    = r_wb;
    assign o_load_total       = OUT_COUNT_BITS'(r_counts.loads);
    assign o_store_total      = OUT_COUNT_BITS'(r_counts.stores);
    assign o_load_miss_total  = OUT_COUNT_BITS'(r_counts.ld_misses);
    assign o_store_miss_total = OUT_COUNT_BITS'(r_counts.st_misses);
    assign o_writeback_total  = OUT_COUNT_BITS'(r_counts.writebacks);

    `SAWC_ASSERT_NOW(a_hit_zero_latency, i_clk, i_rst_n, o_valid && o_hit, o_latency == '0, "hit reported with non-zero latency")
    `SAWC_ASSERT_NOW(a_wb_not_hit, i_clk, i_rst_n, o_valid && o_did_writeback, !o_hit, "writeback reported on a hit")
    `SAWC_ASSERT_NEXT(a_bypass_counts, i_clk, i_rst_n, advance && !cfg.enable, r_counts == $past(counts) && !o_hit && !o_did_writeback, "bypassed access changed counts or flags")

endmodule
